@@ hw/rtl/pdf_pkg.sv @@
// types and constants for the packet descriptor fifo
`timescale 1ns / 1ps

package pdf_pkg;

  // default store depth
  localparam int DEPTH_DEF = 64;

  // field widths
  localparam int BYTES_W  = 24;
  localparam int PTS_W    = 64;
  localparam int SERIAL_W = 16;
  localparam int TOTAL_W  = 30;
  localparam int SPAN_W   = 63;
  localparam int CNT7_W   = 7;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // timestamp code meaning no timestamp
  localparam logic [PTS_W-1:0] PTS_NONE = {1'b1, {(PTS_W-1){1'b0}}};

  // command codes
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 3'd0,
    KIND_POP   = 3'd1,
    KIND_END   = 3'd2,
    KIND_ABORT = 3'd3,
    KIND_FLUSH = 3'd4
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_REFUSED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_PACKETS     = 1'b0,
    REG_BLOCK_WHEN_FULL = 1'b1
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DROP,
    S_DONE
  } state_t;

  // one stored descriptor
  typedef struct packed {
    logic [BYTES_W-1:0]  bytes;
    logic [PTS_W-1:0]    pts;
    logic [SERIAL_W-1:0] serial;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hw/rtl/packet_descriptor_fifo.sv @@
// bounded fifo of packet descriptors with drop-oldest option and status words
`timescale 1ns / 1ps

// Bounded FIFO of packet descriptors (byte size, timestamp, serial) held in one
// descriptor RAM with a registered read. Every input word (push, pop, mark end,
// abort, flush) yields exactly one result word with status, popped descriptor,
// occupancy, bytes held, head-to-tail timestamp span and drained-at-end flag.
// The accept step does the RAM write, or pops the head entry (a register copy
// or the word just read) and reads the next head; the done state then hands
// the result to the output register once that is free. A drop-mode push
// first discards the oldest entries in a drop state, each drop reading the
// next head from the RAM, then writes the new entry. The result sits in an
// output register, so a new word is accepted while the previous result waits.
// The user must have configuration written only while idle; it is not enforced.

module packet_descriptor_fifo #(
  parameter int DEPTH = pdf_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [pdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pdf_pkg::KIND_W-1:0]        in_kind,
  input  logic [pdf_pkg::BYTES_W-1:0]       in_pkt_bytes,
  input  logic signed [pdf_pkg::PTS_W-1:0]  in_pkt_pts,
  input  logic [pdf_pkg::SERIAL_W-1:0]      in_serial_in,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pdf_pkg::STATUS_W-1:0]      out_status,
  output logic [pdf_pkg::BYTES_W-1:0]       out_bytes,
  output logic signed [pdf_pkg::PTS_W-1:0]  out_pts,
  output logic [pdf_pkg::SERIAL_W-1:0]      out_serial,
  output logic [pdf_pkg::CNT7_W-1:0]        out_dropped_count,
  output logic [pdf_pkg::CNT7_W-1:0]        out_occupancy,
  output logic [pdf_pkg::TOTAL_W-1:0]       out_byte_total,
  output logic [pdf_pkg::SPAN_W-1:0]        out_span_ts,
  output logic                              out_drained_eof
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > pdf_pkg::CNT7_W) ? CW : pdf_pkg::CNT7_W;

  // control state
  pdf_pkg::state_t                   state_r, state_nxt;
  logic [AW-1:0]                     head_r, head_nxt;
  logic [AW-1:0]                     tail_r, tail_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [pdf_pkg::TOTAL_W-1:0]       bytes_r, bytes_nxt;
  logic                              end_r, end_nxt;
  logic                              abort_r, abort_nxt;
  logic                              rd_pending_r, rd_pending_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [pdf_pkg::CNT7_W-1:0]        max_packets_r;
  logic                              block_full_r;

  // payload state
  pdf_pkg::entry_t                   hd_r, hd_nxt;
  logic [pdf_pkg::PTS_W-1:0]         last_pts_r, last_pts_nxt;
  pdf_pkg::entry_t                   lat_r, lat_nxt;
  logic [pdf_pkg::STATUS_W-1:0]      res_status_r, res_status_nxt;
  pdf_pkg::entry_t                   res_entry_r, res_entry_nxt;
  logic [CW-1:0]                     res_drops_r, res_drops_nxt;

  // output register
  logic [pdf_pkg::STATUS_W-1:0]      out_status_r, out_status_nxt;
  pdf_pkg::entry_t                   out_entry_r, out_entry_nxt;
  logic [pdf_pkg::CNT7_W-1:0]        out_drops_r, out_drops_nxt;
  logic [pdf_pkg::CNT7_W-1:0]        out_occ_r, out_occ_nxt;
  logic [pdf_pkg::TOTAL_W-1:0]       out_total_r, out_total_nxt;
  logic [pdf_pkg::SPAN_W-1:0]        out_span_r, out_span_nxt;
  logic                              out_drained_r, out_drained_nxt;

  // ram port
  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr;
  pdf_pkg::entry_t                   ram_wdata;
  logic                              ram_re;
  logic [AW-1:0]                     ram_raddr;
  logic [pdf_pkg::ENTRY_W-1:0]       ram_rdata;

  // misc datapath
  pdf_pkg::entry_t                   hd_eff;
  pdf_pkg::entry_t                   push_entry;
  logic                              do_push;
  logic [LW-1:0]                     max_ext;
  logic [LW-1:0]                     limit;
  logic                              at_limit;
  logic [pdf_pkg::PTS_W-1:0]         span_diff;
  logic [pdf_pkg::SPAN_W-1:0]        span_val;
  logic                              span_zero;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // descriptor store
  pdf_ram #(
    .WIDTH (pdf_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // head entry: fresh ram word when a head read is in flight
  assign hd_eff = rd_pending_r ? pdf_pkg::entry_t'(ram_rdata) : hd_r;

  // occupancy limit, zero or above depth means full depth
  assign max_ext  = LW'(max_packets_r);
  assign limit    = (max_ext == '0 || max_ext > LW'(DEPTH)) ? LW'(DEPTH) : max_ext;
  assign at_limit = LW'(count_r) >= limit;

  // head to tail timestamp span
  assign span_diff = last_pts_r - hd_eff.pts;
  assign span_zero = (count_r == '0) || (hd_eff.pts == pdf_pkg::PTS_NONE) ||
                     (last_pts_r == pdf_pkg::PTS_NONE) ||
                     ($signed(last_pts_r) < $signed(hd_eff.pts));
  assign span_val  = span_zero ? '0 :
                     span_diff[pdf_pkg::PTS_W-1] ? {pdf_pkg::SPAN_W{1'b1}} :
                     span_diff[pdf_pkg::SPAN_W-1:0];

  // descriptor written by a push: straight from the port when idle
  always_comb begin
    if (state_r == pdf_pkg::S_IDLE) begin
      push_entry.bytes  = in_pkt_bytes;
      push_entry.pts    = in_pkt_pts;
      push_entry.serial = in_serial_in;
    end else begin
      push_entry = lat_r;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_packets_r <= '0;
      block_full_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (pdf_pkg::cfg_reg_t'(cfg_index))
        pdf_pkg::REG_MAX_PACKETS:     max_packets_r <= cfg_wdata;
        pdf_pkg::REG_BLOCK_WHEN_FULL: block_full_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pdf_pkg::S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      bytes_r      <= '0;
      end_r        <= 1'b0;
      abort_r      <= 1'b0;
      rd_pending_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      bytes_r      <= bytes_nxt;
      end_r        <= end_nxt;
      abort_r      <= abort_nxt;
      rd_pending_r <= rd_pending_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hd_r          <= hd_nxt;
    last_pts_r    <= last_pts_nxt;
    lat_r         <= lat_nxt;
    res_status_r  <= res_status_nxt;
    res_entry_r   <= res_entry_nxt;
    res_drops_r   <= res_drops_nxt;
    out_status_r  <= out_status_nxt;
    out_entry_r   <= out_entry_nxt;
    out_drops_r   <= out_drops_nxt;
    out_occ_r     <= out_occ_nxt;
    out_total_r   <= out_total_nxt;
    out_span_r    <= out_span_nxt;
    out_drained_r <= out_drained_nxt;
  end

  // sequencer: next state, store updates and ram accesses
  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    bytes_nxt       = bytes_r;
    end_nxt         = end_r;
    abort_nxt       = abort_r;
    rd_pending_nxt  = 1'b0;
    hd_nxt          = hd_eff;
    last_pts_nxt    = last_pts_r;
    lat_nxt         = lat_r;
    res_status_nxt  = res_status_r;
    res_entry_nxt   = res_entry_r;
    res_drops_nxt   = res_drops_r;
    out_valid_nxt   = out_valid_r & out_stall;
    out_status_nxt  = out_status_r;
    out_entry_nxt   = out_entry_r;
    out_drops_nxt   = out_drops_r;
    out_occ_nxt     = out_occ_r;
    out_total_nxt   = out_total_r;
    out_span_nxt    = out_span_r;
    out_drained_nxt = out_drained_r;
    ram_re          = 1'b0;
    ram_raddr       = ptr_inc(head_r);
    do_push         = 1'b0;

    unique case (state_r)
      pdf_pkg::S_IDLE: begin
        if (in_valid) begin
          lat_nxt        = push_entry;
          res_status_nxt = pdf_pkg::ST_OK;
          res_entry_nxt  = '0;
          res_drops_nxt  = '0;
          state_nxt      = pdf_pkg::S_DONE;
          case (pdf_pkg::kind_t'(in_kind))
            pdf_pkg::KIND_PUSH: begin
              if (abort_r || end_r) begin
                res_status_nxt = pdf_pkg::ST_REFUSED;
              end else if (at_limit && block_full_r) begin
                res_status_nxt = pdf_pkg::ST_FULL;
              end else if (count_r != '0 && at_limit) begin
                state_nxt = pdf_pkg::S_DROP;
              end else begin
                do_push = 1'b1;
              end
            end
            pdf_pkg::KIND_POP: begin
              if (abort_r) begin
                res_status_nxt = pdf_pkg::ST_REFUSED;
              end else if (count_r == '0) begin
                res_status_nxt = pdf_pkg::ST_EMPTY;
              end else begin
                res_entry_nxt = hd_eff;
                bytes_nxt     = bytes_r - pdf_pkg::TOTAL_W'(hd_eff.bytes);
                head_nxt      = ptr_inc(head_r);
                count_nxt     = count_r - 1'b1;
                // fetch the new head while it exists
                if (count_r > CW'(1)) begin
                  ram_re         = 1'b1;
                  rd_pending_nxt = 1'b1;
                end
              end
            end
            pdf_pkg::KIND_END: begin
              end_nxt = 1'b1;
            end
            pdf_pkg::KIND_ABORT: begin
              abort_nxt = 1'b1;
            end
            pdf_pkg::KIND_FLUSH: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
              bytes_nxt = '0;
              end_nxt   = 1'b0;
              abort_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end

      pdf_pkg::S_DROP: begin
        // discard the oldest entry each cycle until below the limit
        if (count_r != '0 && at_limit) begin
          bytes_nxt     = bytes_r - pdf_pkg::TOTAL_W'(hd_eff.bytes);
          head_nxt      = ptr_inc(head_r);
          count_nxt     = count_r - 1'b1;
          res_drops_nxt = res_drops_r + 1'b1;
          if (count_r > CW'(1)) begin
            ram_re         = 1'b1;
            rd_pending_nxt = 1'b1;
          end
        end else begin
          do_push   = 1'b1;
          state_nxt = pdf_pkg::S_DONE;
        end
      end

      pdf_pkg::S_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_entry_nxt   = res_entry_r;
          out_drops_nxt   = pdf_pkg::CNT7_W'(res_drops_r);
          out_occ_nxt     = pdf_pkg::CNT7_W'(count_r);
          out_total_nxt   = bytes_r;
          out_span_nxt    = span_val;
          out_drained_nxt = end_r && (count_r == '0);
          state_nxt       = pdf_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pdf_pkg::S_IDLE;
      end
    endcase

    // append a descriptor at the tail
    if (do_push) begin
      bytes_nxt    = bytes_r + pdf_pkg::TOTAL_W'(push_entry.bytes);
      tail_nxt     = ptr_inc(tail_r);
      count_nxt    = count_r + 1'b1;
      last_pts_nxt = push_entry.pts;
      if (count_r == '0) begin
        hd_nxt = push_entry;
      end
    end
  end

  assign ram_we    = do_push;
  assign ram_waddr = tail_r;
  assign ram_wdata = push_entry;

  // ports
  assign in_stall          = (state_r != pdf_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_bytes         = out_entry_r.bytes;
  assign out_pts           = out_entry_r.pts;
  assign out_serial        = out_entry_r.serial;
  assign out_dropped_count = out_drops_r;
  assign out_occupancy     = out_occ_r;
  assign out_byte_total    = out_total_r;
  assign out_span_ts       = out_span_r;
  assign out_drained_eof   = out_drained_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty store with head and tail apart");

  a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pending_r |-> (count_r != '0))
    else $error("head read in flight with empty store");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pdf_pkg::S_DONE && !(out_valid_r && out_stall)) |=>
      (out_valid_r && state_r == pdf_pkg::S_IDLE))
    else $error("finished item did not reach the output register");

endmodule

@@ hw/rtl/pdf_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module pdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds its word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ tb/sv/tb_packet_descriptor_fifo.sv @@
// self-checking testbench for the packet descriptor fifo
`timescale 1ns / 1ps

module tb_packet_descriptor_fifo;

  localparam int DEPTH = pdf_pkg::DEPTH_DEF;
  localparam int STUCK_LIMIT = 4000;
  localparam int PHASE_WORDS = 80;
  localparam logic [pdf_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [pdf_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic [pdf_pkg::PTS_W-1:0] PTS_MAX = {1'b0, {(pdf_pkg::PTS_W-1){1'b1}}};
  localparam logic [pdf_pkg::PTS_W-1:0] PTS_MIN_VALID = pdf_pkg::PTS_NONE + 1'b1;

  // one result word as the predictor builds it
  typedef struct packed {
    pdf_pkg::status_t                 status;
    logic [pdf_pkg::BYTES_W-1:0]      bytes;
    logic [pdf_pkg::PTS_W-1:0]        pts;
    logic [pdf_pkg::SERIAL_W-1:0]     serial;
    logic [pdf_pkg::CNT7_W-1:0]       dropped;
    logic [pdf_pkg::CNT7_W-1:0]       occupancy;
    logic [pdf_pkg::TOTAL_W-1:0]      total;
    logic [pdf_pkg::SPAN_W-1:0]       span;
    logic                             drained;
  } fifo_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [pdf_pkg::CFG_IDX_W-1:0]       cfg_index = pdf_pkg::REG_MAX_PACKETS;
  logic [pdf_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [pdf_pkg::KIND_W-1:0]          in_kind = pdf_pkg::KIND_POP;
  logic [pdf_pkg::BYTES_W-1:0]         in_pkt_bytes = '0;
  logic signed [pdf_pkg::PTS_W-1:0]    in_pkt_pts = '0;
  logic [pdf_pkg::SERIAL_W-1:0]        in_serial_in = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [pdf_pkg::STATUS_W-1:0]        out_status;
  logic [pdf_pkg::BYTES_W-1:0]         out_bytes;
  logic signed [pdf_pkg::PTS_W-1:0]    out_pts;
  logic [pdf_pkg::SERIAL_W-1:0]        out_serial;
  logic [pdf_pkg::CNT7_W-1:0]          out_dropped_count;
  logic [pdf_pkg::CNT7_W-1:0]          out_occupancy;
  logic [pdf_pkg::TOTAL_W-1:0]         out_byte_total;
  logic [pdf_pkg::SPAN_W-1:0]          out_span_ts;
  logic                                out_drained_eof;

  // shadow copy of the descriptor store and its registers
  logic [pdf_pkg::BYTES_W-1:0]   held_bytes [DEPTH];
  logic [pdf_pkg::PTS_W-1:0]     held_pts [DEPTH];
  logic [pdf_pkg::SERIAL_W-1:0]  held_serial [DEPTH];
  int unsigned                   head_slot = 0;
  int unsigned                   tail_slot = 0;
  int unsigned                   held_count = 0;
  logic [pdf_pkg::TOTAL_W-1:0]   held_total = '0;
  bit                            end_seen = 1'b0;
  bit                            abort_seen = 1'b0;
  int unsigned                   limit_reg = 0;
  bit                            block_reg = 1'b1;

  fifo_result_t                  expected_q[$];
  int                            mismatch_count = 0;
  int                            stuck_cycles = 0;
  bit                            tx_idle_on = 1'b1;
  bit                            rx_idle_on = 1'b1;
  logic [pdf_pkg::PTS_W-1:0]     pts_clock = '0;

  packet_descriptor_fifo u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_pkt_bytes      (in_pkt_bytes),
    .in_pkt_pts        (in_pkt_pts),
    .in_serial_in      (in_serial_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_bytes         (out_bytes),
    .out_pts           (out_pts),
    .out_serial        (out_serial),
    .out_dropped_count (out_dropped_count),
    .out_occupancy     (out_occupancy),
    .out_byte_total    (out_byte_total),
    .out_span_ts       (out_span_ts),
    .out_drained_eof   (out_drained_eof)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // retire the head descriptor of the shadow store
  function automatic void retire_head();
    held_total = held_total - pdf_pkg::TOTAL_W'(held_bytes[head_slot]);
    head_slot = (head_slot + 1 >= DEPTH) ? 0 : head_slot + 1;
    held_count--;
  endfunction

  // tail minus head timestamp, zero when empty, unstamped or negative
  function automatic logic [pdf_pkg::SPAN_W-1:0] head_to_tail_span();
    int unsigned                      last;
    logic signed [pdf_pkg::PTS_W-1:0] first_ts;
    logic signed [pdf_pkg::PTS_W-1:0] last_ts;
    logic [pdf_pkg::PTS_W-1:0]        diff;
    if (held_count == 0) return '0;
    last = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
    first_ts = held_pts[head_slot];
    last_ts = held_pts[last];
    if (first_ts == pdf_pkg::PTS_NONE || last_ts == pdf_pkg::PTS_NONE || last_ts < first_ts)
      return '0;
    diff = last_ts - first_ts;
    return diff[pdf_pkg::PTS_W-1] ? {pdf_pkg::SPAN_W{1'b1}} : diff[pdf_pkg::SPAN_W-1:0];
  endfunction

  // apply one command word to the shadow store and build its result
  function automatic fifo_result_t predict_word(input logic [pdf_pkg::KIND_W-1:0] kind,
                                                input logic [pdf_pkg::BYTES_W-1:0] bytes,
                                                input logic [pdf_pkg::PTS_W-1:0] pts,
                                                input logic [pdf_pkg::SERIAL_W-1:0] serial);
    fifo_result_t r;
    int unsigned  cap;
    r = '0;
    r.status = pdf_pkg::ST_OK;
    cap = (limit_reg == 0 || limit_reg > DEPTH) ? DEPTH : limit_reg;
    case (kind)
      pdf_pkg::KIND_PUSH: begin
        if (abort_seen || end_seen) begin
          r.status = pdf_pkg::ST_REFUSED;
        end else if (held_count >= cap && block_reg) begin
          r.status = pdf_pkg::ST_FULL;
        end else begin
          // drop mode makes room from the head
          while (held_count > 0 && held_count >= cap) begin
            retire_head();
            r.dropped = r.dropped + 1'b1;
          end
          held_bytes[tail_slot] = bytes;
          held_pts[tail_slot] = pts;
          held_serial[tail_slot] = serial;
          held_total = held_total + pdf_pkg::TOTAL_W'(bytes);
          tail_slot = (tail_slot + 1 >= DEPTH) ? 0 : tail_slot + 1;
          held_count++;
        end
      end
      pdf_pkg::KIND_POP: begin
        if (abort_seen) begin
          r.status = pdf_pkg::ST_REFUSED;
        end else if (held_count == 0) begin
          r.status = pdf_pkg::ST_EMPTY;
        end else begin
          r.bytes = held_bytes[head_slot];
          r.pts = held_pts[head_slot];
          r.serial = held_serial[head_slot];
          retire_head();
        end
      end
      pdf_pkg::KIND_END: begin
        end_seen = 1'b1;
      end
      pdf_pkg::KIND_ABORT: begin
        abort_seen = 1'b1;
      end
      pdf_pkg::KIND_FLUSH: begin
        head_slot = 0;
        tail_slot = 0;
        held_count = 0;
        held_total = '0;
        end_seen = 1'b0;
        abort_seen = 1'b0;
      end
      default: begin
      end
    endcase
    r.occupancy = pdf_pkg::CNT7_W'(held_count);
    r.total = held_total;
    r.span = head_to_tail_span();
    r.drained = end_seen && held_count == 0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, got);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) report_mismatch(what, want, got);
  endtask

  // check each accepted result word, then predict each accepted command word
  always @(posedge clk) begin : result_check
    fifo_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result word with none pending", '0, 64'(out_occupancy));
      end else begin
        want = expected_q.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("bytes", 64'(want.bytes), 64'(out_bytes));
        check_field("pts", want.pts, out_pts);
        check_field("serial", 64'(want.serial), 64'(out_serial));
        check_field("dropped_count", 64'(want.dropped), 64'(out_dropped_count));
        check_field("occupancy", 64'(want.occupancy), 64'(out_occupancy));
        check_field("byte_total", 64'(want.total), 64'(out_byte_total));
        check_field("span_ts", 64'(want.span), 64'(out_span_ts));
        check_field("drained_eof", 64'(want.drained), 64'(out_drained_eof));
      end
    end
    if (rst_n && in_valid && in_stall === 1'b0)
      expected_q.push_back(predict_word(in_kind, in_pkt_bytes, in_pkt_pts, in_serial_in));
  end

  // watchdog on cycles with no traffic on either side
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int unsigned hold;
    wait (rst_n);
    forever begin
      hold = rx_idle_on ? $urandom_range(0, 6) : 0;
      if (hold > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
        @(negedge clk) out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // present one command word, wait for it to be taken, then idle a while
  task automatic send_word(input logic [pdf_pkg::KIND_W-1:0] kind,
                           input logic [pdf_pkg::BYTES_W-1:0] bytes,
                           input logic [pdf_pkg::PTS_W-1:0] pts,
                           input logic [pdf_pkg::SERIAL_W-1:0] serial);
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_pkt_bytes <= bytes;
    in_pkt_pts <= pts;
    in_serial_in <= serial;
    do @(posedge clk); while (in_stall !== 1'b0);
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop sending and let every pending result come out
  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers, written only with the block idle
  task automatic write_limits(input int unsigned limit, input bit block);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= pdf_pkg::REG_MAX_PACKETS;
    cfg_wdata <= pdf_pkg::CFG_DATA_W'(limit);
    @(negedge clk);
    cfg_index <= pdf_pkg::REG_BLOCK_WHEN_FULL;
    cfg_wdata <= pdf_pkg::CFG_DATA_W'(block);
    @(negedge clk) cfg_we <= 1'b0;
    limit_reg = limit;
    block_reg = block;
  endtask

  function automatic logic [pdf_pkg::BYTES_W-1:0] pick_bytes();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return '0;
    if (r < 4) return {pdf_pkg::BYTES_W{1'b1}};
    return pdf_pkg::BYTES_W'($urandom);
  endfunction

  // rising timestamps, plus unstamped, extreme and scattered ones
  function automatic logic [pdf_pkg::PTS_W-1:0] pick_pts();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return pdf_pkg::PTS_NONE;
    if (r == 2) return PTS_MAX;
    if (r == 3) return PTS_MIN_VALID;
    if (r == 4) pts_clock = {$urandom, $urandom};
    if (r < 13) begin
      pts_clock = pts_clock + pdf_pkg::PTS_W'($urandom_range(0, 3000));
      return pts_clock;
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [pdf_pkg::SERIAL_W-1:0] pick_serial();
    return pdf_pkg::SERIAL_W'($urandom);
  endfunction

  task automatic send_cmd(input logic [pdf_pkg::KIND_W-1:0] kind);
    send_word(kind, pdf_pkg::BYTES_W'($urandom), {$urandom, $urandom}, pick_serial());
  endtask

  task automatic test_empty_and_spare();
    send_cmd(pdf_pkg::KIND_POP);
    send_cmd(KIND_SPARE_LO);
    send_cmd(KIND_SPARE_HI);
  endtask

  // unstamped ends, negative span and saturated span
  task automatic test_span_extremes();
    send_word(pdf_pkg::KIND_PUSH, {pdf_pkg::BYTES_W{1'b1}}, pdf_pkg::PTS_NONE,
              {pdf_pkg::SERIAL_W{1'b1}});
    send_word(pdf_pkg::KIND_PUSH, '0, PTS_MAX, '0);
    send_cmd(pdf_pkg::KIND_POP);
    send_word(pdf_pkg::KIND_PUSH, 24'd1, PTS_MIN_VALID, 16'h1234);
    send_cmd(pdf_pkg::KIND_POP);
    send_word(pdf_pkg::KIND_PUSH, 24'd5, PTS_MAX, 16'h0007);
    send_cmd(pdf_pkg::KIND_POP);
    send_cmd(pdf_pkg::KIND_POP);
  endtask

  // end of stream drains, abort refuses both push and pop
  task automatic test_end_and_abort();
    send_word(pdf_pkg::KIND_PUSH, 24'd100, 64'd10, 16'd1);
    send_cmd(pdf_pkg::KIND_END);
    send_word(pdf_pkg::KIND_PUSH, 24'd200, 64'd20, 16'd2);
    send_cmd(pdf_pkg::KIND_POP);
    send_cmd(pdf_pkg::KIND_POP);
    send_cmd(pdf_pkg::KIND_FLUSH);
    send_cmd(pdf_pkg::KIND_ABORT);
    send_word(pdf_pkg::KIND_PUSH, 24'd300, 64'd30, 16'd3);
    send_cmd(pdf_pkg::KIND_POP);
    send_cmd(pdf_pkg::KIND_FLUSH);
  endtask

  // limit lowered under occupancy, then full refusal
  task automatic test_limit_and_drop();
    write_limits(0, 1'b1);
    repeat (4) send_word(pdf_pkg::KIND_PUSH, pick_bytes(), pick_pts(), pick_serial());
    write_limits(2, 1'b0);
    send_word(pdf_pkg::KIND_PUSH, pick_bytes(), pick_pts(), pick_serial());
    write_limits(1, 1'b1);
    send_word(pdf_pkg::KIND_PUSH, pick_bytes(), pick_pts(), pick_serial());
    send_cmd(pdf_pkg::KIND_FLUSH);
  endtask

  // one configuration, then a stretch of mixed traffic
  task automatic run_phase(input int unsigned limit, input bit block,
                           input int unsigned push_pct);
    int unsigned                r;
    logic [pdf_pkg::KIND_W-1:0] kind;
    write_limits(limit, block);
    tx_idle_on = $urandom_range(0, 3) != 0;
    rx_idle_on = $urandom_range(0, 3) != 0;
    repeat (PHASE_WORDS) begin
      r = $urandom_range(0, 99);
      if ((end_seen || abort_seen) && $urandom_range(0, 3) == 0) kind = pdf_pkg::KIND_FLUSH;
      else if (r < push_pct) kind = pdf_pkg::KIND_PUSH;
      else if (r < 95) kind = pdf_pkg::KIND_POP;
      else if (r == 95) kind = pdf_pkg::KIND_END;
      else if (r == 96) kind = pdf_pkg::KIND_ABORT;
      else if (r < 99) kind = pdf_pkg::KIND_FLUSH;
      else kind = pdf_pkg::KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      send_word(kind, pick_bytes(), pick_pts(), pick_serial());
    end
  endtask

  task automatic test_random_traffic();
    run_phase(0, 1'b0, 80);
    run_phase(64, 1'b1, 70);
    run_phase(127, 1'b0, 65);
    run_phase(3, 1'b0, 50);
    run_phase(3, 1'b1, 60);
    run_phase(1, 1'b0, 55);
    run_phase(1, 1'b1, 50);
    run_phase(65, 1'b1, 80);
    run_phase(0, 1'b1, 45);
    run_phase($urandom_range(0, 127), 1'($urandom_range(0, 1)), 55);
  endtask

  // reset, then the tests in turn
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_empty_and_spare();
    test_span_extremes();
    test_end_and_abort();
    test_limit_and_drop();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
